// ===== src/pwm_period_duty_meter_macros.svh =====
// assertion macros for the pwm period and duty meter checker
`ifndef PWM_PERIOD_DUTY_METER_MACROS_SVH
`define PWM_PERIOD_DUTY_METER_MACROS_SVH

// same-cycle implication under clk_i, disabled in reset
`define PWMM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pwmm assertion failed");

// next-cycle implication under clk_i, disabled in reset
`define PWMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pwmm assertion failed");

`endif

// ===== src/pwmm_pkg.sv =====
// package: widths, constants, codes and control types of the pwm meter
`timescale 1ns / 1ps
`default_nettype none

package pwmm_pkg;

  localparam int unsigned STAMP_BITS_DEF = 8;
  localparam int unsigned STEP_BITS      = 8;
  localparam int unsigned FREQ_BITS      = 24;
  localparam int unsigned DUTY_BITS      = 7;
  localparam int unsigned APB_DATA_BITS  = 32;
  localparam int unsigned APB_ADDR_BITS  = 3;

  localparam logic [STEP_BITS-1:0] STEP_RESET = 8'd16;
  localparam logic [FREQ_BITS-1:0] BASE_RESET = 24'd1000000;
  localparam logic [FREQ_BITS-1:0] FREQ_MAX   = 24'hFFFFFF;
  localparam logic [DUTY_BITS-1:0] DUTY_SCALE = 7'd100;

  typedef enum logic [0:0] {
    REG_STEP = 1'b0,
    REG_BASE = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_FALL  = 2'd1,
    PH_CLOSE = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_EVAL  = 4'd1,
    ST_MUL   = 4'd2,
    ST_FLOAD = 4'd3,
    ST_FRUN  = 4'd4,
    ST_DLOAD = 4'd5,
    ST_DRUN  = 4'd6,
    ST_DSAVE = 4'd7,
    ST_WRITE = 4'd8
  } state_e;

  typedef struct packed {
    logic cap;
    logic store_rise;
    logic store_fall;
    logic diff;
    logic mul;
    logic clr_last;
    logic div_load;
    logic div_duty;
    logic div_step;
    logic save_freq;
    logic save_duty;
    logic load_out;
    logic res_arm;
    logic res_done;
    logic res_err;
  } ctrl_cmd_t;

  typedef struct packed {
    logic period_zero;
    logic div_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/pwmm_if.sv =====
// stream interfaces: edge stamp requests in, measurement results out
`timescale 1ns / 1ps
`default_nettype none

interface pwmm_in_if #(
  parameter int unsigned STAMP_BITS = pwmm_pkg::STAMP_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [STAMP_BITS-1:0] stamp;

  modport source (output valid, output stamp, input ready);
  modport sink (input valid, input stamp, output ready);
endinterface

interface pwmm_out_if;
  import pwmm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 arm_falling;
  logic                 done_res;
  logic [FREQ_BITS-1:0] frequency;
  logic [DUTY_BITS-1:0] duty_percent;
  logic                 period_error;

  modport source (output valid, output arm_falling, output done_res, output frequency,
                  output duty_percent, output period_error, input ready);
  modport sink (input valid, input arm_falling, input done_res, input frequency,
                input duty_percent, input period_error, output ready);
endinterface

`default_nettype wire

// ===== src/pwmm_regs.sv =====
// apb configuration registers: step time and time base
`timescale 1ns / 1ps
`default_nettype none

module pwmm_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pwmm_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [pwmm_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic      [pwmm_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                     pready,
  output logic      [pwmm_pkg::STEP_BITS-1:0]      step_o,
  output logic      [pwmm_pkg::FREQ_BITS-1:0]      base_o
);
  import pwmm_pkg::*;

  logic [STEP_BITS-1:0] step_q;
  logic [FREQ_BITS-1:0] base_q;
  reg_idx_e             idx;
  logic                 wr_en;

  assign idx    = reg_idx_e'(paddr[APB_ADDR_BITS-1]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
      base_q <= BASE_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_STEP: step_q <= pwdata[STEP_BITS-1:0];
        REG_BASE: base_q <= pwdata[FREQ_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_STEP: prdata = APB_DATA_BITS'(step_q);
      REG_BASE: prdata = APB_DATA_BITS'(base_q);
      default:  prdata = '0;
    endcase
  end

  assign step_o = step_q;
  assign base_o = base_q;

endmodule

`default_nettype wire

// ===== src/pwmm_ctrl.sv =====
// controller: edge phase tracking and sequencing of the measurement datapath
`timescale 1ns / 1ps
`default_nettype none

module pwmm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire pwmm_pkg::dp_stat_t   stat_i,
  output pwmm_pkg::ctrl_cmd_t       cmd_o
);
  import pwmm_pkg::*;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   arm_q, arm_d;
  logic   done_q, done_d;
  logic   err_q, err_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_FIRST;
      arm_q       <= 1'b0;
      done_q      <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      arm_q       <= arm_d;
      done_q      <= done_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    arm_d        = arm_q;
    done_d       = done_q;
    err_d        = err_q;
    cmd_o        = '0;
    cmd_o.res_arm  = arm_q;
    cmd_o.res_done = done_q;
    cmd_o.res_err  = err_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        case (phase_q)
          PH_FIRST: begin
            cmd_o.store_rise = 1'b1;
            arm_d   = 1'b1;
            done_d  = 1'b0;
            err_d   = 1'b0;
            phase_d = PH_FALL;
            state_d = ST_WRITE;
          end
          PH_FALL: begin
            cmd_o.store_fall = 1'b1;
            arm_d   = 1'b0;
            done_d  = 1'b0;
            err_d   = 1'b0;
            phase_d = PH_CLOSE;
            state_d = ST_WRITE;
          end
          default: begin
            cmd_o.diff = 1'b1;
            arm_d   = 1'b0;
            done_d  = 1'b1;
            err_d   = 1'b0;
            phase_d = PH_FIRST;
            state_d = ST_MUL;
          end
        endcase
      end
      ST_MUL: begin
        if (stat_i.period_zero) begin
          cmd_o.clr_last = 1'b1;
          err_d   = 1'b1;
          state_d = ST_WRITE;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = ST_FLOAD;
        end
      end
      ST_FLOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_FRUN;
      end
      ST_FRUN: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_DLOAD;
        end
      end
      ST_DLOAD: begin
        cmd_o.save_freq = 1'b1;
        cmd_o.div_load  = 1'b1;
        cmd_o.div_duty  = 1'b1;
        state_d         = ST_DRUN;
      end
      ST_DRUN: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_duty = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_DSAVE;
        end
      end
      ST_DSAVE: begin
        cmd_o.save_duty = 1'b1;
        state_d         = ST_WRITE;
      end
      ST_WRITE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.load_out || (out_valid_q && !out_ready_i);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== src/pwmm_dp.sv =====
// datapath: stamp registers, products, shared restoring divider, result register
`timescale 1ns / 1ps
`default_nettype none

module pwmm_dp #(
  parameter int unsigned STAMP_BITS = pwmm_pkg::STAMP_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire pwmm_pkg::ctrl_cmd_t             cmd_i,
  output pwmm_pkg::dp_stat_t                   stat_o,
  input  wire logic [STAMP_BITS-1:0]           stamp_i,
  input  wire logic [pwmm_pkg::STEP_BITS-1:0]  step_i,
  input  wire logic [pwmm_pkg::FREQ_BITS-1:0]  base_i,
  output logic                                 arm_falling_o,
  output logic                                 done_res_o,
  output logic      [pwmm_pkg::FREQ_BITS-1:0]  frequency_o,
  output logic      [pwmm_pkg::DUTY_BITS-1:0]  duty_percent_o,
  output logic                                 period_error_o
);
  import pwmm_pkg::*;

  localparam int unsigned PROD_F_BITS = STAMP_BITS + STEP_BITS;
  localparam int unsigned PROD_D_BITS = STAMP_BITS + DUTY_BITS;
  localparam int unsigned NUM_BITS    = (PROD_D_BITS > FREQ_BITS) ? PROD_D_BITS : FREQ_BITS;
  localparam int unsigned DEN_BITS    = PROD_F_BITS;
  localparam int unsigned CNT_BITS    = $clog2(NUM_BITS);

  logic [STAMP_BITS-1:0]  stamp_q;
  logic [STAMP_BITS-1:0]  rise_q;
  logic [STAMP_BITS-1:0]  fall_q;
  logic [STAMP_BITS-1:0]  period_q;
  logic [STAMP_BITS-1:0]  high_q;
  logic [PROD_F_BITS-1:0] prod_f_q;
  logic [PROD_D_BITS-1:0] prod_d_q;
  logic [NUM_BITS-1:0]    num_q, num_d;
  logic [DEN_BITS-1:0]    den_q;
  logic [DEN_BITS-1:0]    rem_q, rem_d;
  logic [CNT_BITS-1:0]    cnt_q;
  logic [FREQ_BITS-1:0]   last_freq_q;
  logic [DUTY_BITS-1:0]   last_duty_q;
  logic [DEN_BITS:0]      trial;
  logic [DEN_BITS:0]      trial_sub;
  logic                   ge;
  logic [FREQ_BITS-1:0]   freq_sat;
  logic [DUTY_BITS-1:0]   duty_sat;

  // one restoring division step per cycle
  assign trial     = {rem_q, num_q[NUM_BITS-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign ge        = (trial >= {1'b0, den_q});
  assign rem_d     = ge ? trial_sub[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
  assign num_d     = {num_q[NUM_BITS-2:0], ge};

  assign freq_sat = (num_q > NUM_BITS'(FREQ_MAX)) ? FREQ_MAX : num_q[FREQ_BITS-1:0];
  assign duty_sat = (num_q > NUM_BITS'(DUTY_SCALE)) ? DUTY_SCALE : num_q[DUTY_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      stamp_q <= stamp_i;
    end
    if (cmd_i.diff) begin
      period_q <= stamp_q - rise_q;
      high_q   <= fall_q - rise_q;
    end
    if (cmd_i.mul) begin
      prod_f_q <= PROD_F_BITS'(period_q) * PROD_F_BITS'(step_i);
      prod_d_q <= PROD_D_BITS'(high_q) * PROD_D_BITS'(DUTY_SCALE);
    end
    if (cmd_i.div_load) begin
      rem_q <= '0;
      if (cmd_i.div_duty) begin
        num_q <= NUM_BITS'(prod_d_q);
        den_q <= DEN_BITS'(period_q);
      end else begin
        num_q <= NUM_BITS'(base_i);
        den_q <= prod_f_q;
      end
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      num_q <= num_d;
    end
    if (cmd_i.load_out) begin
      arm_falling_o  <= cmd_i.res_arm;
      done_res_o     <= cmd_i.res_done;
      frequency_o    <= last_freq_q;
      duty_percent_o <= last_duty_q;
      period_error_o <= cmd_i.res_err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q      <= '0;
      fall_q      <= '0;
      last_freq_q <= '0;
      last_duty_q <= '0;
      cnt_q       <= '0;
    end else begin
      if (cmd_i.store_rise) begin
        rise_q <= stamp_q;
      end
      if (cmd_i.store_fall) begin
        fall_q <= stamp_q;
      end
      if (cmd_i.clr_last) begin
        last_freq_q <= '0;
        last_duty_q <= '0;
      end
      if (cmd_i.save_freq) begin
        last_freq_q <= freq_sat;
      end
      if (cmd_i.save_duty) begin
        last_duty_q <= duty_sat;
      end
      if (cmd_i.div_load) begin
        cnt_q <= CNT_BITS'(NUM_BITS - 1);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign stat_o.period_zero = (period_q == '0);
  assign stat_o.div_last    = (cnt_q == '0);

endmodule

`default_nettype wire

// ===== src/pwm_period_duty_meter.sv =====
// first rising and falling edge: captured in IDLE, stored in EVAL, result loaded in WRITE
// closing edge: EVAL, MUL, FLOAD, FRUN, DLOAD, DRUN, DSAVE, WRITE; N = max(24, STAMP_BITS+7) bits in the
// shared restoring divider, one quotient bit per cycle, frequency then duty; zero period skips to WRITE
// one request in flight; the next is taken while the previous result waits in the output register
// reset: asynchronous, active low; phase, rise and fall stamps and last results clear, registers to defaults
// top level: pwm period and duty meter
`timescale 1ns / 1ps
`default_nettype none

module pwm_period_duty_meter #(
  parameter int unsigned STAMP_BITS = pwmm_pkg::STAMP_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  pwmm_in_if.sink                                  in_if,
  pwmm_out_if.source                               out_if,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pwmm_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [pwmm_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic      [pwmm_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                     pready
);
  import pwmm_pkg::*;

  ctrl_cmd_t            cmd;
  dp_stat_t             stat;
  logic [STEP_BITS-1:0] step;
  logic [FREQ_BITS-1:0] base;

  pwmm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .step_o  (step),
    .base_o  (base)
  );

  pwmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pwmm_dp #(
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .stamp_i        (in_if.stamp),
    .step_i         (step),
    .base_i         (base),
    .arm_falling_o  (out_if.arm_falling),
    .done_res_o     (out_if.done_res),
    .frequency_o    (out_if.frequency),
    .duty_percent_o (out_if.duty_percent),
    .period_error_o (out_if.period_error)
  );

endmodule

`default_nettype wire

// ===== src/pwmm_checker.sv =====
// port-level checker for the pwm meter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "pwm_period_duty_meter_macros.svh"

module pwmm_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            out_valid_i,
  input wire logic                            out_ready_i,
  input wire logic                            arm_falling_i,
  input wire logic                            done_res_i,
  input wire logic [pwmm_pkg::FREQ_BITS-1:0]  frequency_i,
  input wire logic [pwmm_pkg::DUTY_BITS-1:0]  duty_percent_i,
  input wire logic                            period_error_i
);
  import pwmm_pkg::*;

  `PWMM_ASSERT_NOW(a_close_arms_rise, out_valid_i && done_res_i, !arm_falling_i)
  `PWMM_ASSERT_NOW(a_err_zeroes, out_valid_i && period_error_i,
                   done_res_i && (frequency_i == '0) && (duty_percent_i == '0))
  `PWMM_ASSERT_NOW(a_duty_range, out_valid_i, duty_percent_i <= DUTY_SCALE)
  `PWMM_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
                    out_valid_i && $stable(frequency_i) && $stable(duty_percent_i))

endmodule

bind pwm_period_duty_meter pwmm_checker u_pwmm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_if.valid),
  .out_ready_i    (out_if.ready),
  .arm_falling_i  (out_if.arm_falling),
  .done_res_i     (out_if.done_res),
  .frequency_i    (out_if.frequency),
  .duty_percent_i (out_if.duty_percent),
  .period_error_i (out_if.period_error)
);

`default_nettype wire
